@@ src/ssid_pkg.sv @@
// Shared constants, codes and the ordering function of the sorted set unit.
package ssid_pkg;

	localparam int VALUE_W       = 32;
	localparam int STATUS_W      = 3;
	localparam int COUNT_W       = 5;
	localparam int DEPTH_DEFAULT = 16;

	// request codes (s_tuser)
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// register index, taken from paddr[2]
	localparam logic REG_ORDER = 1'b0;

	// true when a belongs strictly before b under the chosen order
	function automatic logic goes_before(input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b, input logic desc);
		logic lt;
		logic gt;
		lt = $signed(a) < $signed(b);
		gt = $signed(a) > $signed(b);
		return desc ? gt : lt;
	endfunction

endpackage

@@ src/sorted_set_insert_delete_unit.sv @@
// Sorted set of distinct signed values held in a single table memory.
//
// The unit keeps up to DEPTH distinct 32-bit signed values in a table memory
// (one write port, one registered read port), in ascending order,
// or descending when bit 0 of the register at byte address 0 is set. Each
// item on the s_ side is an insert or a delete (s_tuser) of s_tdata; each
// gives exactly one result item on the m_ side with a status, the entry count
// afterwards, the first stored value (zero when empty) and an empty flag.
// One item is worked on at a time: the table is scanned entry by entry for
// a match and the insert position, then entries are moved one place per
// cycle through the memory port to open or close the gap, then entry 0 is
// read back. The result sits in an output register, so the next item is
// taken while it still waits. The table is not cleared after reset: only
// entries below the count are ever used. Changing the order while values
// are stored does not reorder them; later inserts go in front of the first
// stored entry they precede under the new order.
module sorted_set_insert_delete_unit #(
	parameter int DEPTH = ssid_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// request items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] func (0 insert, 1 delete)
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [2:0] status, [7:3] count, [39:8] first_value,
	                               // [40] empty_res, [47:41] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // table index
	localparam int CW = $clog2(DEPTH + 1);                 // count 0..DEPTH
	localparam int VW = ssid_pkg::VALUE_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [6:0] {
		IDLE  = 7'b0000001,
		SCAN  = 7'b0000010,
		SHIFT = 7'b0000100,
		PLACE = 7'b0001000,
		RD0   = 7'b0010000,
		FIRST = 7'b0100000,
		HOLD  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic desc_q;

	// request under work
	logic          func_q;
	logic [VW-1:0] val_q;
	logic [ssid_pkg::STATUS_W-1:0] status_q;

	// table occupancy
	logic [CW-1:0] cnt_q;

	// scan
	logic [CW-1:0] scan_idx_q;
	logic          rv_s1;
	logic [CW-1:0] ridx_s1;
	logic          found_q;
	logic [CW-1:0] match_idx_q;
	logic          pos_found_q;
	logic [CW-1:0] ins_pos_q;

	// move
	logic [CW-1:0] wr_idx_q;
	logic          wv_s1;
	logic [AW-1:0] wa_s1;

	// table memory
	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [VW-1:0] wdata;

	// output register
	logic                          m_tvalid_q;
	logic [ssid_pkg::STATUS_W-1:0] out_status_q;
	logic [ssid_pkg::COUNT_W-1:0]  out_count_q;
	logic [VW-1:0]                 out_first_q;
	logic                          out_empty_q;

	logic [CW-1:0] nxt_up;
	logic [CW-1:0] nxt_dn;
	logic          sh_cond;
	logic          rd_eq;
	logic          rd_bef;
	logic          out_free;
	logic [CW+ssid_pkg::COUNT_W-1:0] cnt_wide;
	logic          cfg_wr;

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_empty_q, out_first_q, out_count_q, out_status_q};
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == ssid_pkg::REG_ORDER) ? {31'd0, desc_q} : 32'd0;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ssid_pkg::REG_ORDER);

	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_wide = {{ssid_pkg::COUNT_W{1'b0}}, cnt_q};

	// compare of the entry read back during the scan
	assign rd_eq  = (rdata_q == val_q);
	assign rd_bef = ssid_pkg::goes_before(val_q, rdata_q, desc_q);

	// move step: delete pulls entries down, insert pushes them up
	assign nxt_up  = wr_idx_q + 1'b1;
	assign nxt_dn  = wr_idx_q - 1'b1;
	assign sh_cond = (func_q == ssid_pkg::FUNC_DELETE) ? (nxt_up < cnt_q)
	                                                   : (wr_idx_q > ins_pos_q);

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = wa_s1;
		wdata = rdata_q;
		case (state_q)
			SCAN: begin
				raddr = scan_idx_q[AW-1:0];
			end
			SHIFT: begin
				raddr = (func_q == ssid_pkg::FUNC_DELETE) ? nxt_up[AW-1:0] : nxt_dn[AW-1:0];
				we    = wv_s1;
			end
			PLACE: begin
				we    = 1'b1;
				waddr = ins_pos_q[AW-1:0];
				wdata = val_q;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_wr) begin
			desc_q <= pwdata[0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cnt_q        <= '0;
			rv_s1        <= 1'b0;
			wv_s1        <= 1'b0;
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			pos_found_q  <= 1'b0;
			m_tvalid_q   <= 1'b0;
			func_q       <= 1'b0;
			val_q        <= '0;
			status_q     <= '0;
			ridx_s1      <= '0;
			match_idx_q  <= '0;
			ins_pos_q    <= '0;
			wr_idx_q     <= '0;
			wa_s1        <= '0;
			out_status_q <= '0;
			out_count_q  <= '0;
			out_first_q  <= '0;
			out_empty_q  <= 1'b0;
		end else begin
			// HOLD reloads the output register itself
			if (m_tready && state_q != HOLD)
				m_tvalid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						func_q      <= s_tuser;
						val_q       <= s_tdata;
						scan_idx_q  <= '0;
						rv_s1       <= 1'b0;
						found_q     <= 1'b0;
						pos_found_q <= 1'b0;
						ins_pos_q   <= cnt_q;
						match_idx_q <= cnt_q;
						state_q     <= SCAN;
					end
				end
				SCAN: begin
					// entry read last cycle is compared now
					if (rv_s1) begin
						if (rd_eq && !found_q) begin
							found_q     <= 1'b1;
							match_idx_q <= ridx_s1;
						end
						if (rd_bef && !pos_found_q) begin
							pos_found_q <= 1'b1;
							ins_pos_q   <= ridx_s1;
						end
					end
					if (scan_idx_q < cnt_q) begin
						rv_s1      <= 1'b1;
						ridx_s1    <= scan_idx_q;
						scan_idx_q <= scan_idx_q + 1'b1;
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) begin
							// every stored entry has been compared
							wv_s1 <= 1'b0;
							if (func_q == ssid_pkg::FUNC_INSERT) begin
								if (found_q) begin
									status_q <= ssid_pkg::ST_PRESENT;
									state_q  <= RD0;
								end else if (cnt_q == DEPTH_C) begin
									status_q <= ssid_pkg::ST_FULL;
									state_q  <= RD0;
								end else begin
									status_q <= ssid_pkg::ST_INSERTED;
									wr_idx_q <= cnt_q;
									state_q  <= SHIFT;
								end
							end else begin
								if (found_q) begin
									status_q <= ssid_pkg::ST_DELETED;
									wr_idx_q <= match_idx_q;
									state_q  <= SHIFT;
								end else begin
									status_q <= ssid_pkg::ST_MISSING;
									state_q  <= RD0;
								end
							end
						end
					end
				end
				SHIFT: begin
					if (sh_cond) begin
						wv_s1    <= 1'b1;
						wa_s1    <= wr_idx_q[AW-1:0];
						wr_idx_q <= (func_q == ssid_pkg::FUNC_DELETE) ? nxt_up : nxt_dn;
					end else begin
						wv_s1 <= 1'b0;
						if (!wv_s1) begin
							// last move written
							if (func_q == ssid_pkg::FUNC_DELETE) begin
								cnt_q   <= cnt_q - 1'b1;
								state_q <= RD0;
							end else begin
								state_q <= PLACE;
							end
						end
					end
				end
				PLACE: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= RD0;
				end
				RD0: begin
					state_q <= FIRST;
				end
				FIRST: begin
					// rdata_q now holds entry 0
					state_q <= HOLD;
				end
				HOLD: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= status_q;
						out_count_q  <= cnt_wide[ssid_pkg::COUNT_W-1:0];
						out_first_q  <= (cnt_q == '0) ? '0 : rdata_q;
						out_empty_q  <= (cnt_q == '0);
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the sorted set insert/delete unit.
module tb;

	localparam int DEPTH       = ssid_pkg::DEPTH_DEFAULT;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 180;
	localparam int POOL_N      = 20;
	localparam int QUIET_LIMIT = 2000;	// cycles with no handshake anywhere
	localparam int DRAIN_WAIT  = 2 * DEPTH + 10;

	// register byte addresses: order bit, and a slot that decodes to no register
	localparam logic [2:0] ADDR_ORDER = 3'd0;
	localparam logic [2:0] ADDR_SPARE = 3'd4;

	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic [ssid_pkg::STATUS_W-1:0] status;
		logic [ssid_pkg::COUNT_W-1:0]  count;
		logic [ssid_pkg::VALUE_W-1:0]  first_value;
		logic                          empty_res;
	} result_t;

	// Tracks the set contents and order bit, and the results owed by the unit.
	class set_tracker;
		int unsigned depth;
		logic [ssid_pkg::VALUE_W-1:0] stored[$];
		logic descending;
		result_t awaited[$];
		int errors;
		int requests;
		int tally[5];

		function new(int unsigned d);
			depth = d;
			descending = 1'b0;
		endfunction

		function bit precedes(logic [ssid_pkg::VALUE_W-1:0] a,
			logic [ssid_pkg::VALUE_W-1:0] b);
			return descending ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] data);
			if (addr[2] == ssid_pkg::REG_ORDER)
				descending = data[0];
		endfunction

		function void note_request(logic func, logic [ssid_pkg::VALUE_W-1:0] value);
			int pos;
			int unsigned n;
			result_t r;
			pos = stored.size();
			foreach (stored[i])
				if (stored[i] == value && pos == stored.size())
					pos = i;
			if (func == ssid_pkg::FUNC_INSERT) begin
				if (pos < stored.size()) begin
					r.status = ssid_pkg::ST_PRESENT;
				end else if (stored.size() >= depth) begin
					r.status = ssid_pkg::ST_FULL;
				end else begin
					// goes in front of the first entry it precedes, else at the tail
					pos = 0;
					while (pos < stored.size() && !precedes(value, stored[pos]))
						pos++;
					stored.insert(pos, value);
					r.status = ssid_pkg::ST_INSERTED;
				end
			end else begin
				if (pos < stored.size()) begin
					stored.delete(pos);
					r.status = ssid_pkg::ST_DELETED;
				end else begin
					r.status = ssid_pkg::ST_MISSING;
				end
			end
			n = stored.size();
			r.count = n[ssid_pkg::COUNT_W-1:0];
			r.first_value = (stored.size() > 0) ? stored[0] : '0;
			r.empty_res = (stored.size() == 0);
			tally[r.status]++;
			requests++;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [47:0] word);
			result_t r;
			if (awaited.size() == 0) begin
				$error("result item with nothing outstanding: %h", word);
				errors++;
				return;
			end
			r = awaited.pop_front();
			compare_field("status", 32'(r.status), 32'(word[2:0]));
			compare_field("count", 32'(r.count), 32'(word[7:3]));
			compare_field("first_value", r.first_value, word[39:8]);
			compare_field("empty_res", 32'(r.empty_res), 32'(word[40]));
			compare_field("pad", 32'd0, 32'(word[47:41]));
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int size();
			return stored.size();
		endfunction

		function logic [ssid_pkg::VALUE_W-1:0] any_stored();
			if (stored.size() == 0)
				return $urandom;
			return stored[$urandom_range(0, stored.size() - 1)];
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;	// [31:0] value
	logic        s_tuser = 1'b0;	// [0] func (0 insert, 1 delete)
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;	// [2:0] status, [7:3] count, [39:8] first_value, [40] empty_res
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	set_tracker board = new(DEPTH);
	bit steady = 1'b0;	// when set, neither side inserts gaps
	int quiet_cycles = 0;
	int orders_seen[2];

	sorted_set_insert_delete_unit #(.DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap length in cycles: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: sample before the edge's updates land, then pick the next
	// ready level. One nonblocking write to m_tready per edge.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: any handshake on either stream or the register port resets it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// One request item. Valid stays high straight into the next item when the
	// gap is zero, so it is never lowered and raised in the same step.
	task automatic send_request(input logic func, input logic [31:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		board.note_request(func, value);
	endtask

	// Drop valid and let every outstanding result come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(addr, data);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Read the order register back and compare with the tracked bit.
	task automatic apb_check_order();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_ORDER;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== board.descending) begin
			$error("order readback: expected %0b, got %0b", board.descending, prdata[0]);
			board.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random phase: a small value pool so that hits, misses and a full table
	// all turn up; the fill direction swings between empty and full.
	task automatic run_random_phase(input int n);
		logic [31:0] pool[POOL_N];
		bit filling;
		int r;
		logic func;
		logic [31:0] value;
		foreach (pool[i]) begin
			r = $urandom_range(0, 3);
			case (r)
				0: begin
					case ($urandom_range(0, 4))
						0: pool[i] = INT_MIN;
						1: pool[i] = INT_MAX;
						2: pool[i] = 32'h0;
						3: pool[i] = 32'hffff_ffff;
						default: pool[i] = 32'h1;
					endcase
				end
				1: pool[i] = $urandom_range(0, 40) - 20;
				default: pool[i] = $urandom;
			endcase
		end
		filling = 1'($urandom_range(0, 1));
		for (int i = 0; i < n; i++) begin
			if (board.size() == DEPTH)
				filling = 1'b0;
			else if (board.size() == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				filling = !filling;
			r = $urandom_range(0, 99);
			func = (r < (filling ? 70 : 30)) ? ssid_pkg::FUNC_INSERT : ssid_pkg::FUNC_DELETE;
			r = $urandom_range(0, 99);
			if (func == ssid_pkg::FUNC_INSERT)
				value = (r < 85) ? pool[$urandom_range(0, POOL_N - 1)] : $urandom;
			else if (r < 60)
				value = board.any_stored();
			else
				value = (r < 90) ? pool[$urandom_range(0, POOL_N - 1)] : $urandom;
			send_request(func, value);
		end
		settle();
	endtask

	initial begin
		logic order;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value written explicitly, then read back
		apb_write(ADDR_ORDER, 32'h0);
		apb_check_order();
		orders_seen[0]++;

		// Directed: delete on an empty set, extremes, a duplicate insert,
		// removal of the head, a miss, then fill to the top and push past it.
		send_request(ssid_pkg::FUNC_DELETE, 32'd7);
		send_request(ssid_pkg::FUNC_INSERT, INT_MAX);
		send_request(ssid_pkg::FUNC_INSERT, INT_MIN);
		send_request(ssid_pkg::FUNC_INSERT, 32'h0);
		send_request(ssid_pkg::FUNC_INSERT, 32'hffff_ffff);
		send_request(ssid_pkg::FUNC_INSERT, 32'h1);
		send_request(ssid_pkg::FUNC_INSERT, 32'h0);
		send_request(ssid_pkg::FUNC_DELETE, INT_MIN);
		send_request(ssid_pkg::FUNC_DELETE, 32'd12345);
		for (int k = 2; k < 14; k++)
			send_request(ssid_pkg::FUNC_INSERT, (k % 2) ? -(k * 1000) : (k * 1000));
		send_request(ssid_pkg::FUNC_INSERT, 32'h1234_5678);	// table full: dropped
		send_request(ssid_pkg::FUNC_INSERT, INT_MAX);		// full, but already present
		send_request(ssid_pkg::FUNC_DELETE, 32'hffff_ffff);
		settle();

		// Phases alternate the order; the set is usually not empty when it
		// flips, so stale ordering of stored entries gets exercised. Upper
		// bits of the written word are junk, and the spare slot is poked.
		for (int p = 0; p < PHASES; p++) begin
			order = (p % 2 == 0);
			steady = (p % 4 == 3);
			if (p % 3 == 1)
				apb_write(ADDR_SPARE, $urandom);
			apb_write(ADDR_ORDER, {31'($urandom_range(0, 32'h7fff_ffff)), order});
			apb_check_order();
			orders_seen[order]++;
			run_random_phase(PHASE_ITEMS);
		end

		steady = 1'b0;
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d requests: %0d inserted, %0d present, %0d deleted, %0d missing, %0d full",
			board.requests, board.tally[ssid_pkg::ST_INSERTED],
			board.tally[ssid_pkg::ST_PRESENT], board.tally[ssid_pkg::ST_DELETED],
			board.tally[ssid_pkg::ST_MISSING], board.tally[ssid_pkg::ST_FULL]);
		$display("Order settings: %0d ascending, %0d descending phases; %0d mismatches",
			orders_seen[0], orders_seen[1], board.errors);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
